[hw/rtl/ryuv_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the RGB to YUV 4:2:0 encoder.
package ryuv_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CFG_W      = 13;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned HGT_W      = 13;
    localparam int unsigned SUM_W      = 10;
    localparam int unsigned LINE_W     = 2 * SUM_W;
    localparam int unsigned ACC_W      = 17;

    localparam int unsigned MAX_HEIGHT     = 4096;
    localparam int unsigned FRAME_W_RESET  = 640;
    localparam int unsigned FRAME_H_RESET  = 480;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int unsigned K_YR = 66;
    localparam int unsigned K_YG = 129;
    localparam int unsigned K_YB = 25;
    localparam int unsigned K_UR = 38;
    localparam int unsigned K_UG = 74;
    localparam int unsigned K_UB = 112;
    localparam int unsigned K_VR = 112;
    localparam int unsigned K_VG = 94;
    localparam int unsigned K_VB = 18;
    localparam int unsigned RND_OFS  = 128;
    localparam int unsigned UV_OFS   = 32768 + 128;
    localparam int unsigned Y_BIAS   = 16;
    localparam int unsigned AVG_RND  = 2;

    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic frame_last;
    } t_pix_ctrl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_line_ctl;

endpackage

[hw/rtl/rgb_to_yuv420_encoder.sv]
`timescale 1ns / 1ps
// RGB to YUV 4:2:0 encoder: top level with counters, pipeline and chroma averaging.
//
// Pixels enter in raster order on the input channel (i_in_valid / o_in_ready,
// payload i_red, i_green, i_blue). Each accepted item yields exactly one
// result item on the output channel (o_out_valid / i_out_ready): the pixel's
// luma, and on the last pixel of each 2x2 block the averaged chroma with
// o_chroma_valid set. o_frame_end marks the last pixel of a frame.
// Frame size is written on the configuration channel (index 0 width,
// index 1 height); o_cfg_ready is always high.
// An accepted item passes the input, conversion and output registers in turn;
// one item per cycle is taken while the receiver does not stall. Pair sums
// of even rows sit in a single-port line store of MAX_WIDTH/2 entries,
// written on the odd pixel of an even row and read on the even pixel of an
// odd row, so one access per item at most. Reset clears the pipeline and
// the position counters and loads width 640 and height 480. When the
// receiver stalls, the result holds in the output register and bubbles
// ahead of it still fill; o_in_ready drops only when every stage is full.
module rgb_to_yuv420_encoder
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_luma,
    output logic             o_chroma_valid,
    output logic [PIX_W-1:0] o_chroma_u,
    output logic [PIX_W-1:0] o_chroma_v,
    output logic             o_frame_end,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int C_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int A_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_W  = (FRAME_W_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RESET;

    function automatic logic [W_BITS-1:0] limit_w(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] v;
        v = d & ~CFG_W'(1);
        if (v < CFG_W'(2)) v = CFG_W'(2);
        if (32'(v) > 32'(MAX_WIDTH)) return W_BITS'(MAX_WIDTH);
        return W_BITS'(v);
    endfunction

    function automatic logic [HGT_W-1:0] limit_h(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] v;
        v = d & ~CFG_W'(1);
        if (v < CFG_W'(2)) v = CFG_W'(2);
        if (32'(v) > 32'(MAX_HEIGHT)) return HGT_W'(MAX_HEIGHT);
        return HGT_W'(v);
    endfunction

    logic [W_BITS-1:0] r_width;
    logic [HGT_W-1:0]  r_height;
    logic [C_BITS-1:0] r_col;
    logic [ROW_W-1:0]  r_row;

    logic              r_v1;
    logic [PIX_W-1:0]  r_red1;
    logic [PIX_W-1:0]  r_green1;
    logic [PIX_W-1:0]  r_blue1;
    t_pix_ctrl         r_c1;
    logic [A_BITS-1:0] r_slot1;

    logic              r_v2;
    t_pix_ctrl         r_c2;
    logic [A_BITS-1:0] r_slot2;
    logic [PIX_W-1:0]  y2;
    logic [PIX_W-1:0]  u2;
    logic [PIX_W-1:0]  v2;
    logic [PIX_W-1:0]  r_held_u;
    logic [PIX_W-1:0]  r_held_v;

    logic              r_v3;
    logic [PIX_W-1:0]  r_luma;
    logic              r_cvalid;
    logic [PIX_W-1:0]  r_cu;
    logic [PIX_W-1:0]  r_cv;
    logic              r_fend;

    logic              adv1;
    logic              adv2;
    logic              adv3;
    logic              in_acc;
    logic              fire2;
    logic              row_last;
    logic              frame_last;
    logic [W_BITS:0]   col_inc;
    logic [HGT_W-1:0]  row_inc;
    t_pix_ctrl         c_now;
    t_line_ctl         line_ctl;
    logic [LINE_W-1:0] line_wr;
    logic [LINE_W-1:0] line_rd;
    logic [10:0]       su;
    logic [10:0]       sv;
    logic [10:0]       su_r;
    logic [10:0]       sv_r;
    logic              blk_end;

    assign adv3       = !r_v3 || i_out_ready;
    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign o_in_ready = adv1;
    assign in_acc     = i_in_valid && adv1;
    assign fire2      = r_v2 && adv3;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        col_inc          = (W_BITS + 1)'(r_col) + (W_BITS + 1)'(1);
        row_inc          = HGT_W'(r_row) + HGT_W'(1);
        row_last         = col_inc >= (W_BITS + 1)'(r_width);
        frame_last       = row_last && (row_inc >= r_height);
        c_now.odd_col    = r_col[0];
        c_now.odd_row    = r_row[0];
        c_now.frame_last = frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_BITS'(RST_W);
            r_height <= HGT_W'(FRAME_H_RESET);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_width <= limit_w(i_cfg_data);
            end else begin
                r_height <= limit_h(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (frame_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_last) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + C_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red1   <= i_red;
            r_green1 <= i_green;
            r_blue1  <= i_blue;
            r_c1     <= c_now;
            r_slot1  <= A_BITS'(r_col >> 1);
        end
        if (adv2 && r_v1) begin
            r_c2    <= r_c1;
            r_slot2 <= r_slot1;
        end
    end

    ryuv_csc u_csc (
        .i_clk   (i_clk),
        .i_en    (adv2 && r_v1),
        .i_red   (r_red1),
        .i_green (r_green1),
        .i_blue  (r_blue1),
        .o_luma  (y2),
        .o_u     (u2),
        .o_v     (v2)
    );

    always_comb begin
        line_ctl.rd_en = fire2 && !r_c2.odd_col && r_c2.odd_row;
        line_ctl.wr_en = fire2 && r_c2.odd_col && !r_c2.odd_row;
        line_wr = {SUM_W'(r_held_v) + SUM_W'(v2), SUM_W'(r_held_u) + SUM_W'(u2)};
        su      = 11'(line_rd[SUM_W-1:0]) + 11'(r_held_u) + 11'(u2);
        sv      = 11'(line_rd[LINE_W-1:SUM_W]) + 11'(r_held_v) + 11'(v2);
        su_r    = su + 11'(AVG_RND);
        sv_r    = sv + 11'(AVG_RND);
        blk_end = r_c2.odd_col && r_c2.odd_row;
    end

    ryuv_line_mem #(
        .DEPTH  (DEPTH),
        .A_BITS (A_BITS)
    ) u_line (
        .i_clk     (i_clk),
        .i_ctl     (line_ctl),
        .i_addr    (r_slot2),
        .i_wr_data (line_wr),
        .o_rd_data (line_rd)
    );

    always_ff @(posedge i_clk) begin
        if (fire2) begin
            if (!r_c2.odd_col) begin
                r_held_u <= u2;
                r_held_v <= v2;
            end
            r_luma   <= y2;
            r_cvalid <= blk_end;
            r_cu     <= blk_end ? su_r[9:2] : '0;
            r_cv     <= blk_end ? sv_r[9:2] : '0;
            r_fend   <= r_c2.frame_last;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_luma         = r_luma;
    assign o_chroma_valid = r_cvalid;
    assign o_chroma_u     = r_cu;
    assign o_chroma_v     = r_cv;
    assign o_frame_end    = r_fend;

endmodule

[hw/rtl/ryuv_csc.sv]
`timescale 1ns / 1ps
// Color space conversion stage: registered Y, U and V of one pixel.
module ryuv_csc
    import ryuv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic [PIX_W-1:0] o_luma,
    output logic [PIX_W-1:0] o_u,
    output logic [PIX_W-1:0] o_v
);

    logic [ACC_W-1:0] y_sum;
    logic [ACC_W-1:0] u_sum;
    logic [ACC_W-1:0] v_sum;
    logic [PIX_W-1:0] r_luma;
    logic [PIX_W-1:0] r_u;
    logic [PIX_W-1:0] r_v;

    always_comb begin
        y_sum = ACC_W'(RND_OFS) + ACC_W'(K_YR) * ACC_W'(i_red)
              + ACC_W'(K_YG) * ACC_W'(i_green) + ACC_W'(K_YB) * ACC_W'(i_blue);
        u_sum = ACC_W'(UV_OFS) + ACC_W'(K_UB) * ACC_W'(i_blue)
              - ACC_W'(K_UR) * ACC_W'(i_red) - ACC_W'(K_UG) * ACC_W'(i_green);
        v_sum = ACC_W'(UV_OFS) + ACC_W'(K_VR) * ACC_W'(i_red)
              - ACC_W'(K_VG) * ACC_W'(i_green) - ACC_W'(K_VB) * ACC_W'(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma <= y_sum[15:8] + PIX_W'(Y_BIAS);
            r_u    <= u_sum[15:8];
            r_v    <= v_sum[15:8];
        end
    end

    assign o_luma = r_luma;
    assign o_u    = r_u;
    assign o_v    = r_v;

endmodule

[hw/rtl/ryuv_line_mem.sv]
`timescale 1ns / 1ps
// Line store of pair sums: one write port, one registered read port.
module ryuv_line_mem
    import ryuv_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int A_BITS = 11
) (
    input  logic              i_clk,
    input  t_line_ctl         i_ctl,
    input  logic [A_BITS-1:0] i_addr,
    input  logic [LINE_W-1:0] i_wr_data,
    output logic [LINE_W-1:0] o_rd_data
);

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/ryuv_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the encoder and its bind to the top level.
module ryuv_checker
    import ryuv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] o_luma,
    input logic             o_chroma_valid,
    input logic [PIX_W-1:0] o_chroma_u,
    input logic [PIX_W-1:0] o_chroma_v,
    input logic             o_frame_end
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_luma)
            && $stable(o_chroma_valid) && $stable(o_chroma_u)
            && $stable(o_chroma_v) && $stable(o_frame_end))
        else $error("stalled result changed");

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chroma_valid |-> o_chroma_u == '0 && o_chroma_v == '0)
        else $error("chroma nonzero without chroma_valid");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output free");

endmodule

bind rgb_to_yuv420_encoder ryuv_checker u_ryuv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_luma         (o_luma),
    .o_chroma_valid (o_chroma_valid),
    .o_chroma_u     (o_chroma_u),
    .o_chroma_v     (o_chroma_v),
    .o_frame_end    (o_frame_end)
);
